/* rtl/vt52_pkg.sv */
// Shared types and constants for the VT52 escape decoder.
`default_nettype none
package vt52_pkg;
    typedef enum logic [3:0] {
        ACT_PUT    = 4'd0,
        ACT_SCROLL = 4'd1,
        ACT_CLEAR  = 4'd2,
        ACT_ERASE  = 4'd3,
        ACT_BELL   = 4'd4,
        ACT_FG     = 4'd5,
        ACT_BG     = 4'd6,
        ACT_REV_ON = 4'd7,
        ACT_REV_OFF= 4'd8,
        ACT_NONE   = 4'd9
    } t_action;

    localparam logic [1:0] CFG_COLS   = 2'd0;
    localparam logic [1:0] CFG_ROWS   = 2'd1;
    localparam logic [1:0] CFG_VBELL  = 2'd2;
    localparam logic [1:0] CFG_NLCR   = 2'd3;

    localparam logic [2:0] ESC_PLAIN = 3'd0;
    localparam logic [2:0] ESC_CTRL  = 3'd1;
    localparam logic [2:0] ESC_ROW   = 3'd2;
    localparam logic [2:0] ESC_COL   = 3'd3;
    localparam logic [2:0] ESC_FG    = 3'd4;
    localparam logic [2:0] ESC_BG    = 3'd5;

    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_BEL = 8'd7;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_ESC = 8'd27;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_DEL = 8'h7f;

    localparam int MAX_RESULTS = 8;

    typedef struct packed {
        t_action    action;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
        logic [7:0] value;
    } t_cmd;

    // one byte after classification: up to three fixed commands plus a tab run
    typedef struct packed {
        t_cmd [2:0] cmd;
        logic [2:0] cmd_valid;
        logic       tab;
        logic [7:0] tab_start;
        logic [7:0] tab_stop;
        logic [7:0] tab_row;
        logic [7:0] cursor_x;
        logic [7:0] cursor_y;
        logic       cursor_enabled;
    } t_job;
endpackage
`default_nettype wire

/* rtl/vt52_stream_if.sv */
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface vt52_stream_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/vt52_front.sv */
// Front end: takes bytes, updates terminal state, produces one job per byte.
`default_nettype none
module vt52_front
    import vt52_pkg::*;
#(
    parameter int TAB_STOP = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [7:0] i_num_columns,
    input  wire logic [7:0] i_num_rows,
    input  wire logic       i_visual_bell,
    input  wire logic       i_newline_adds_return,
    output logic            o_job_valid,
    input  wire logic       i_job_ready,
    output t_job            o_job
);
    logic [2:0] r_esc, n_esc;
    logic [7:0] r_col, n_col, r_row, n_row, r_scol, n_scol, r_srow, n_srow;
    logic       r_wrap, n_wrap, r_con, n_con, r_rev, n_rev;
    t_job       n_job;
    logic [1:0] ncmd;
    logic [7:0] cols, rows;
    logic [8:0] tstop;

    assign cols = (i_num_columns == 8'd0) ? 8'd1 : i_num_columns;
    assign rows = (i_num_rows == 8'd0) ? 8'd1 : i_num_rows;
    assign o_ready = !o_job_valid || i_job_ready;

    function automatic t_cmd mk(t_action a, logic [7:0] x, logic [7:0] y,
                                logic [7:0] w, logic [7:0] h, logic [7:0] v);
        t_cmd c;
        c.action = a; c.pos_x = x; c.pos_y = y;
        c.rect_width = w; c.rect_height = h; c.value = v;
        return c;
    endfunction

    function automatic logic [7:0] addr(logic [7:0] c, logic [7:0] sz);
        logic [7:0] p;
        if (sz > 8'd127) p = (c < CH_SP) ? 8'd0 : c - CH_SP;
        else p = {1'b0, 7'(c - CH_SP)};
        return (p >= sz) ? sz - 8'd1 : p;
    endfunction

    // next multiple of TAB_STOP above col
    function automatic logic [8:0] next_stop(logic [7:0] col);
        logic [8:0] s;
        s = 9'(TAB_STOP);
        for (int k = 1; k * TAB_STOP < 256; k++) begin
            if ({1'b0, col} >= 9'(k * TAB_STOP)) s = 9'((k + 1) * TAB_STOP);
        end
        return s;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [7:0] rest;
        logic       second;
        n_esc = r_esc; n_col = r_col; n_row = r_row; n_scol = r_scol; n_srow = r_srow;
        n_wrap = r_wrap; n_con = r_con; n_rev = r_rev;
        n_job = '0;
        ncmd = 2'd0;
        tstop = '0;
        for (int pass = 0; pass < 2; pass++) begin
            second = (pass == 1);
            c = second ? CH_CR : i_data_byte;
            rest = (n_col < cols) ? cols - n_col : 8'd0;
            if (!second || (i_data_byte == CH_LF && i_newline_adds_return)) begin
                case (n_esc)
                    ESC_PLAIN: begin
                        case (c)
                            CH_NUL, CH_DEL: ;
                            CH_BEL: if (!i_visual_bell) begin
                                n_job.cmd[ncmd] = mk(ACT_BELL, 0, 0, 0, 0, 0);
                                n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                            end
                            CH_BS: begin
                                n_job.cmd[ncmd] = mk(ACT_ERASE, n_col, n_row, rest, 1, 0);
                                n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                if (n_col > 0) n_col = n_col - 8'd1;
                            end
                            CH_TAB: begin
                                tstop = next_stop(n_col);
                                if (tstop >= {1'b0, cols}) tstop = {1'b0, cols - 8'd1};
                                n_job.tab = 1'b1;
                                n_job.tab_start = n_col;
                                n_job.tab_stop = tstop[7:0];
                                n_job.tab_row = n_row;
                                n_col = tstop[7:0];
                            end
                            CH_LF: begin
                                if ({1'b0, n_row} + 9'd1 >= {1'b0, rows}) begin
                                    n_job.cmd[ncmd] = mk(ACT_SCROLL, 0, 0, 0, 0, 0);
                                    n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                    n_row = rows - 8'd1;
                                end else n_row = n_row + 8'd1;
                            end
                            CH_CR: n_col = 8'd0;
                            CH_ESC: n_esc = ESC_CTRL;
                            default: begin
                                n_job.cmd[ncmd] = mk(ACT_PUT, n_col, n_row, 0, 0, c);
                                n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                if ({1'b0, n_col} + 9'd1 >= {1'b0, cols}) begin
                                    if (!n_wrap) n_col = cols - 8'd1;
                                    else begin
                                        n_col = 8'd0;
                                        if ({1'b0, n_row} + 9'd1 >= {1'b0, rows}) begin
                                            n_job.cmd[ncmd] = mk(ACT_SCROLL, 0, 0, 0, 0, 0);
                                            n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                            n_row = rows - 8'd1;
                                        end else n_row = n_row + 8'd1;
                                    end
                                end else n_col = n_col + 8'd1;
                            end
                        endcase
                    end
                    ESC_CTRL: begin
                        n_esc = ESC_PLAIN;
                        case (c)
                            "A": if (n_row > 0) n_row = n_row - 8'd1;
                            "B": n_row = ({1'b0, n_row} + 9'd1 >= {1'b0, rows}) ?
                                         rows - 8'd1 : n_row + 8'd1;
                            "C": n_col = ({1'b0, n_col} + 9'd1 >= {1'b0, cols}) ?
                                         cols - 8'd1 : n_col + 8'd1;
                            "D": if (n_col > 0) n_col = n_col - 8'd1;
                            "E": begin
                                n_job.cmd[ncmd] = mk(ACT_CLEAR, 0, 0, 0, 0, 0);
                                n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                n_col = 8'd0; n_row = 8'd0;
                            end
                            "H": begin n_col = 8'd0; n_row = 8'd0; end
                            "I": begin
                                if (n_row > 0) n_row = n_row - 8'd1;
                                else begin
                                    n_job.cmd[ncmd] = mk(ACT_SCROLL, 0, 0, 0, 0, 0);
                                    n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                end
                            end
                            "J": begin
                                if ({1'b0, n_row} + 9'd1 < {1'b0, rows}) begin
                                    n_job.cmd[ncmd] = mk(ACT_ERASE, 0, n_row + 8'd1, cols,
                                                         rows - 8'd1 - n_row, 0);
                                    n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                end
                                n_job.cmd[ncmd] = mk(ACT_ERASE, n_col, n_row, rest, 1, 0);
                                n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                            end
                            "K": begin
                                n_job.cmd[ncmd] = mk(ACT_ERASE, n_col, n_row, rest, 1, 0);
                                n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                            end
                            "L", "M": begin
                                if ({1'b0, n_row} + 9'd1 < {1'b0, rows}) begin
                                    n_job.cmd[ncmd] = mk(ACT_SCROLL, 0, 0, 0, 0, 0);
                                    n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                end
                                n_col = 8'd0;
                            end
                            "Y": n_esc = ESC_ROW;
                            "b": n_esc = ESC_FG;
                            "c": n_esc = ESC_BG;
                            "d": begin
                                if (n_row > 0) begin
                                    n_job.cmd[ncmd] = mk(ACT_ERASE, 0, 0, cols, n_row, 0);
                                    n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                end
                                if (n_col > 0) begin
                                    n_job.cmd[ncmd] = mk(ACT_ERASE, 0, n_row, n_col, 1, 0);
                                    n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                end
                            end
                            "e": n_con = 1'b1;
                            "f": n_con = 1'b0;
                            "j": begin n_scol = n_col; n_srow = n_row; end
                            "k": begin n_col = r_scol; n_row = r_srow; end
                            "l": begin
                                n_job.cmd[ncmd] = mk(ACT_ERASE, 0, n_row, cols, 1, 0);
                                n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                n_col = 8'd0;
                            end
                            "o": if (n_col > 0) begin
                                n_job.cmd[ncmd] = mk(ACT_ERASE, 0, n_row, n_col, 1, 0);
                                n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                            end
                            "p": if (!n_rev) begin
                                n_job.cmd[ncmd] = mk(ACT_REV_ON, 0, 0, 0, 0, 0);
                                n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                n_rev = 1'b1;
                            end
                            "q": if (n_rev) begin
                                n_job.cmd[ncmd] = mk(ACT_REV_OFF, 0, 0, 0, 0, 0);
                                n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                                n_rev = 1'b0;
                            end
                            "v": n_wrap = 1'b1;
                            "w": n_wrap = 1'b0;
                            default: ;
                        endcase
                    end
                    ESC_ROW: begin n_row = addr(c, rows); n_esc = ESC_COL; end
                    ESC_COL: begin n_col = addr(c, cols); n_esc = ESC_PLAIN; end
                    ESC_FG: begin
                        n_job.cmd[ncmd] = mk(ACT_FG, 0, 0, 0, 0, c);
                        n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                        n_esc = ESC_PLAIN;
                    end
                    ESC_BG: begin
                        n_job.cmd[ncmd] = mk(ACT_BG, 0, 0, 0, 0, c);
                        n_job.cmd_valid[ncmd] = 1'b1; ncmd = ncmd + 2'd1;
                        n_esc = ESC_PLAIN;
                    end
                    default: n_esc = ESC_PLAIN;
                endcase
            end
        end
        n_job.cursor_x = n_col;
        n_job.cursor_y = n_row;
        n_job.cursor_enabled = n_con;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= ESC_PLAIN; r_col <= '0; r_row <= '0; r_scol <= '0; r_srow <= '0;
            r_wrap <= 1'b1; r_con <= 1'b1; r_rev <= 1'b0;
            o_job_valid <= 1'b0;
        end else begin
            o_job_valid <= (i_valid && o_ready) || (o_job_valid && !i_job_ready);
            if (i_valid && o_ready) begin
                r_esc <= n_esc; r_col <= n_col; r_row <= n_row;
                r_scol <= n_scol; r_srow <= n_srow;
                r_wrap <= n_wrap; r_con <= n_con; r_rev <= n_rev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) o_job <= n_job;
    end

    a_esc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc <= ESC_BG) else $error("escape state out of range");
    a_job_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid && !i_job_ready |=> o_job_valid && $stable(o_job))
        else $error("job changed while stalled");
endmodule
`default_nettype wire

/* rtl/vt52_queue.sv */
// Short job queue between front and back ends.
`default_nettype none
module vt52_queue
    import vt52_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_job      o_job
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue overfilled");
endmodule
`default_nettype wire

/* rtl/vt52_back.sv */
// Back end: walks each job and emits its result items one per cycle while the output is not stalled.
`default_nettype none
module vt52_back
    import vt52_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cmd      o_cmd,
    output logic [7:0] o_cursor_x,
    output logic [7:0] o_cursor_y,
    output logic      o_cursor_enabled,
    output logic      o_last
);
    // step 0..2: fixed commands, then tab spaces from tab_start, then none
    logic [1:0] r_slot;
    logic [3:0] r_toff;
    logic [3:0] r_emitted;
    logic       busy_ok;
    logic       have_fixed, nxt_fixed, tab_any, tab_more;
    t_cmd       cur;
    logic       last_now;
    logic [3:0] vmask;
    logic [7:0] tab_pos;
    logic [7:0] tab_end;

    assign busy_ok = !o_valid || i_ready;
    assign tab_end = i_job.tab_stop;
    assign vmask   = {1'b0, i_job.cmd_valid};
    assign tab_pos = i_job.tab_start + {4'd0, r_toff};
    assign tab_any = i_job.tab && (i_job.tab_start < tab_end);

    always_comb begin
        have_fixed = vmask[r_slot];
        nxt_fixed  = (r_slot != 2'd3) && vmask[r_slot + 2'd1];
        tab_more   = tab_any && (tab_pos < tab_end) && (r_emitted < 4'(MAX_RESULTS));
        cur        = '0;
        cur.action = ACT_NONE;
        if (have_fixed) begin
            cur = i_job.cmd[r_slot];
        end else if (tab_more) begin
            cur = '0;
            cur.action = ACT_PUT;
            cur.pos_x  = tab_pos;
            cur.pos_y  = i_job.tab_row;
            cur.value  = CH_SP;
        end
        if (have_fixed) last_now = !nxt_fixed && !tab_any;
        else if (tab_more) last_now = (tab_pos + 8'd1 >= tab_end) ||
            (r_emitted + 4'd1 >= 4'(MAX_RESULTS));
        else last_now = 1'b1;
    end

    assign o_ready = i_valid && busy_ok && last_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_slot <= 2'd0; r_toff <= '0; r_emitted <= '0;
        end else if (busy_ok) begin
            o_valid <= i_valid;
            if (i_valid) begin
                if (last_now) begin
                    r_slot <= 2'd0; r_toff <= '0; r_emitted <= '0;
                end else begin
                    r_emitted <= r_emitted + 4'd1;
                    if (have_fixed) r_slot <= nxt_fixed ? r_slot + 2'd1 : 2'd3;
                    else r_toff <= r_toff + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (busy_ok && i_valid) begin
            o_cmd <= cur;
            o_cursor_x <= i_job.cursor_x;
            o_cursor_y <= i_job.cursor_y;
            o_cursor_enabled <= i_job.cursor_enabled;
            o_last <= last_now;
        end
    end

    a_emit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted < 4'(MAX_RESULTS)) else $error("too many results");
    a_pop_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> i_valid) else $error("pop without job");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cmd) && $stable(o_last))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

/* rtl/vt52_escape_decoder.sv */
// Top level of the VT52 escape decoder.
//  channel   dir  payload
//  in_ch     in   data_byte
//  out_ch    out  action, pos, rect, value, cursor, last
//  cfg       in   write enable, index, data
// One byte is accepted per cycle unless the front end's job output is stalled by a full queue.
// A byte that gives N results holds the back end until all N have left; tab runs set N.
// A two-entry job queue decouples byte intake from result delivery.
// Synchronous active-low reset; no clearing pass.
`default_nettype none
module vt52_escape_decoder
    import vt52_pkg::*;
#(
    parameter int TAB_STOP = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    vt52_stream_if.sink     in_ch,
    vt52_stream_if.source   out_ch,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);
    logic [7:0] r_cols, r_rows;
    logic       r_vbell, r_nlcr;
    logic       fj_valid, fj_ready, qj_valid, qj_ready;
    t_job       fjob, qjob;
    t_cmd       cmd;
    logic [7:0] cx, cy;
    logic       ce, lst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 8'd80; r_rows <= 8'd25; r_vbell <= 1'b0; r_nlcr <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLS:  r_cols  <= i_cfg_data;
                CFG_ROWS:  r_rows  <= i_cfg_data;
                CFG_VBELL: r_vbell <= i_cfg_data[0];
                CFG_NLCR:  r_nlcr  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    vt52_front #(.TAB_STOP(TAB_STOP)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(in_ch.valid), .o_ready(in_ch.ready), .i_data_byte(in_ch.data),
        .i_num_columns(r_cols), .i_num_rows(r_rows),
        .i_visual_bell(r_vbell), .i_newline_adds_return(r_nlcr),
        .o_job_valid(fj_valid), .i_job_ready(fj_ready), .o_job(fjob)
    );

    vt52_queue #(.DEPTH(2)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(fj_valid), .o_ready(fj_ready), .i_job(fjob),
        .o_valid(qj_valid), .i_ready(qj_ready), .o_job(qjob)
    );

    vt52_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(qj_valid), .o_ready(qj_ready), .i_job(qjob),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_cmd(cmd),
        .o_cursor_x(cx), .o_cursor_y(cy), .o_cursor_enabled(ce), .o_last(lst)
    );

    assign out_ch.data = {cmd.action, cmd.pos_x, cmd.pos_y, cmd.rect_width,
                          cmd.rect_height, cmd.value, cx, cy, ce, lst};
endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the VT52 escape decoder.
`default_nettype none
module tb;
    import vt52_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_action    action;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
        logic [7:0] value;
        logic [7:0] cursor_x;
        logic [7:0] cursor_y;
        logic       cursor_enabled;
        logic       last;
    } t_result;

    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = CFG_COLS;
    logic [7:0] i_cfg_data = 8'd0;

    vt52_stream_if #(.WIDTH(8)) in_ch ();
    vt52_stream_if #(.WIDTH($bits(t_result))) out_ch ();

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = 8'd0;
        out_ch.ready = 1'b0;
    end

    vt52_escape_decoder #(.TAB_STOP(8)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch.sink),
        .out_ch      (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // terminal model state
    int unsigned scr_cols, scr_rows, vbell, lf_cr;
    int unsigned esc_st, cur_col, cur_row, sav_col, sav_row;
    int unsigned wrap_en, cur_on, rev_vid;
    t_cmd        cmd_run[$];
    t_result     expected_q[$];

    int unsigned errors = 0;
    int unsigned burst_left = 0;
    int unsigned hold_req = 0;
    int unsigned cycles = 0;

    function automatic int unsigned ncols();
        return (scr_cols != 0) ? scr_cols : 1;
    endfunction

    function automatic int unsigned nrows();
        return (scr_rows != 0) ? scr_rows : 1;
    endfunction

    function automatic int unsigned line_rest();
        return (cur_col < ncols()) ? ncols() - cur_col : 0;
    endfunction

    function automatic int unsigned yaddr(int unsigned c, int unsigned size);
        int unsigned p;
        if (size > 127) p = (c < 32) ? 0 : c - 32;
        else p = (c + 224) & 32'h7f;
        return (p >= size) ? size - 1 : p;
    endfunction

    task automatic push_cmd(t_action a, int unsigned px, int unsigned py,
                            int unsigned w, int unsigned h, int unsigned v);
        t_cmd c;
        if (cmd_run.size() < MAX_RESULTS) begin
            c.action = a;
            c.pos_x = px[7:0];
            c.pos_y = py[7:0];
            c.rect_width = w[7:0];
            c.rect_height = h[7:0];
            c.value = v[7:0];
            cmd_run.push_back(c);
        end
    endtask

    task automatic line_down();
        if (cur_row + 1 >= nrows()) begin
            push_cmd(ACT_SCROLL, 0, 0, 0, 0, 0);
            cur_row = nrows() - 1;
        end else begin
            cur_row++;
        end
    endtask

    task automatic text_byte(int unsigned c);
        int unsigned stop;
        case (c)
            CH_NUL, CH_DEL: ;
            CH_BEL: if (vbell == 0) push_cmd(ACT_BELL, 0, 0, 0, 0, 0);
            CH_BS: begin
                push_cmd(ACT_ERASE, cur_col, cur_row, line_rest(), 1, 0);
                if (cur_col > 0) cur_col--;
            end
            CH_TAB: begin
                stop = (cur_col / 8 + 1) * 8;
                if (stop >= ncols()) stop = ncols() - 1;
                for (int unsigned i = cur_col; i < stop; i++)
                    push_cmd(ACT_PUT, i, cur_row, 0, 0, CH_SP);
                cur_col = stop;
            end
            CH_LF: line_down();
            CH_CR: cur_col = 0;
            CH_ESC: esc_st = ESC_CTRL;
            default: begin
                push_cmd(ACT_PUT, cur_col, cur_row, 0, 0, c);
                if (cur_col + 1 >= ncols()) begin
                    if (wrap_en == 0) begin
                        cur_col = ncols() - 1;
                    end else begin
                        cur_col = 0;
                        line_down();
                    end
                end else begin
                    cur_col++;
                end
            end
        endcase
    endtask

    task automatic escape_letter(int unsigned c);
        esc_st = ESC_PLAIN;
        case (c)
            "A": if (cur_row > 0) cur_row--;
            "B": cur_row = (cur_row + 1 >= nrows()) ? nrows() - 1 : cur_row + 1;
            "C": cur_col = (cur_col + 1 >= ncols()) ? ncols() - 1 : cur_col + 1;
            "D": if (cur_col > 0) cur_col--;
            "E": begin
                push_cmd(ACT_CLEAR, 0, 0, 0, 0, 0);
                cur_col = 0;
                cur_row = 0;
            end
            "H": begin
                cur_col = 0;
                cur_row = 0;
            end
            "I": if (cur_row > 0) cur_row--; else push_cmd(ACT_SCROLL, 0, 0, 0, 0, 0);
            "J": begin
                if (cur_row + 1 < nrows())
                    push_cmd(ACT_ERASE, 0, cur_row + 1, ncols(), nrows() - 1 - cur_row, 0);
                push_cmd(ACT_ERASE, cur_col, cur_row, line_rest(), 1, 0);
            end
            "K": push_cmd(ACT_ERASE, cur_col, cur_row, line_rest(), 1, 0);
            "L", "M": begin
                if (cur_row + 1 < nrows()) push_cmd(ACT_SCROLL, 0, 0, 0, 0, 0);
                cur_col = 0;
            end
            "Y": esc_st = ESC_ROW;
            "b": esc_st = ESC_FG;
            "c": esc_st = ESC_BG;
            "d": begin
                if (cur_row > 0) push_cmd(ACT_ERASE, 0, 0, ncols(), cur_row, 0);
                if (cur_col > 0) push_cmd(ACT_ERASE, 0, cur_row, cur_col, 1, 0);
            end
            "e": cur_on = 1;
            "f": cur_on = 0;
            "j": begin
                sav_col = cur_col;
                sav_row = cur_row;
            end
            "k": begin
                cur_col = sav_col;
                cur_row = sav_row;
            end
            "l": begin
                push_cmd(ACT_ERASE, 0, cur_row, ncols(), 1, 0);
                cur_col = 0;
            end
            "o": if (cur_col > 0) push_cmd(ACT_ERASE, 0, cur_row, cur_col, 1, 0);
            "p": if (rev_vid == 0) begin
                push_cmd(ACT_REV_ON, 0, 0, 0, 0, 0);
                rev_vid = 1;
            end
            "q": if (rev_vid != 0) begin
                push_cmd(ACT_REV_OFF, 0, 0, 0, 0, 0);
                rev_vid = 0;
            end
            "v": wrap_en = 1;
            "w": wrap_en = 0;
            default: ;
        endcase
    endtask

    task automatic decode_byte(int unsigned c);
        case (esc_st)
            ESC_PLAIN: text_byte(c);
            ESC_CTRL: escape_letter(c);
            ESC_ROW: begin
                cur_row = yaddr(c, nrows());
                esc_st = ESC_COL;
            end
            ESC_COL: begin
                cur_col = yaddr(c, ncols());
                esc_st = ESC_PLAIN;
            end
            ESC_FG: begin
                push_cmd(ACT_FG, 0, 0, 0, 0, c);
                esc_st = ESC_PLAIN;
            end
            ESC_BG: begin
                push_cmd(ACT_BG, 0, 0, 0, 0, c);
                esc_st = ESC_PLAIN;
            end
            default: esc_st = ESC_PLAIN;
        endcase
    endtask

    task automatic predict_commands(logic [7:0] b);
        t_result r;
        cmd_run.delete();
        decode_byte(32'(b));
        if (b == CH_LF && lf_cr != 0) decode_byte(32'(CH_CR));
        if (cmd_run.size() == 0) push_cmd(ACT_NONE, 0, 0, 0, 0, 0);
        foreach (cmd_run[k]) begin
            r.action = cmd_run[k].action;
            r.pos_x = cmd_run[k].pos_x;
            r.pos_y = cmd_run[k].pos_y;
            r.rect_width = cmd_run[k].rect_width;
            r.rect_height = cmd_run[k].rect_height;
            r.value = cmd_run[k].value;
            r.cursor_x = cur_col[7:0];
            r.cursor_y = cur_row[7:0];
            r.cursor_enabled = cur_on[0];
            r.last = (k == cmd_run.size() - 1);
            expected_q.push_back(r);
        end
    endtask

    // result checker: a transfer happens at the next rising edge
    always @(negedge i_clk) begin
        t_result got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: act %0d/%0d px %0d/%0d py %0d/%0d",
                                 want.action, got.action, want.pos_x, got.pos_x,
                                 want.pos_y, got.pos_y,
                                 " w %0d/%0d h %0d/%0d v %0d/%0d",
                                 want.rect_width, got.rect_width,
                                 want.rect_height, got.rect_height, want.value, got.value,
                                 " cx %0d/%0d cy %0d/%0d ce %0b/%0b last %0b/%0b",
                                 want.cursor_x, got.cursor_x, want.cursor_y, got.cursor_y,
                                 want.cursor_enabled, got.cursor_enabled, want.last, got.last);
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        int unsigned hold_cnt;
        int unsigned mode;
        if (hold_req != 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (cycles % 64 == 0) mode = $urandom_range(0, 3);
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_ch.ready <= 1'b0;
        end else begin
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                2: out_ch.ready <= ($urandom_range(0, 4) == 0);
                default: out_ch.ready <= ((cycles % 7) < 4);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        bit taken;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data <= b;
        do begin
            @(negedge i_clk);
            taken = in_ch.ready;
            @(posedge i_clk);
        end while (!taken);
        predict_commands(b);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_COLS: scr_cols = 32'(val);
            CFG_ROWS: scr_rows = 32'(val);
            CFG_VBELL: vbell = 32'(val[0]);
            default: lf_cr = 32'(val[0]);
        endcase
    endtask

    task automatic send_esc(logic [7:0] letter);
        send_byte(CH_ESC);
        send_byte(letter);
    endtask

    task automatic send_goto(logic [7:0] r, logic [7:0] c);
        send_esc("Y");
        send_byte(r);
        send_byte(c);
    endtask

    function automatic logic [7:0] pick_letter();
        string letters = "ABCDEHIJKLMYbcdefjklopqvwZa";
        return letters[$urandom_range(0, letters.len() - 1)];
    endfunction

    task automatic test_text_and_controls();
        send_byte("A");
        send_byte(8'hff);
        send_byte(CH_NUL);
        send_byte(CH_DEL);
        send_byte(CH_BEL);
        send_byte(CH_TAB);
        send_byte(CH_BS);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(8'h80);
        send_goto(8'd56, 8'd110);
        send_byte(CH_TAB);
        send_byte("z");
        send_esc("I");
        send_esc("p");
        send_esc("p");
        send_esc("q");
        send_esc("q");
        send_esc("b");
        send_byte(8'hff);
        send_esc("c");
        send_byte(8'h00);
        send_esc("X");
    endtask

    task automatic test_escapes();
        byte unsigned lst[] = '{"A", "B", "C", "D", "E", "H", "I", "J", "K", "L", "M",
                                "d", "e", "f", "j", "k", "l", "o", "v", "w"};
        foreach (lst[i]) begin
            send_goto(8'(32 + $urandom_range(0, 30)), 8'(32 + $urandom_range(0, 90)));
            send_esc(lst[i]);
        end
        send_goto(8'd0, 8'd31);
        send_goto(8'd255, 8'd255);
        send_esc("w");
        repeat (4) send_byte("w");
        send_esc("v");
    endtask

    task automatic random_mix(int unsigned n);
        int unsigned k;
        for (int unsigned i = 0; i < n; i += k) begin
            k = 1;
            case ($urandom_range(0, 9))
                0, 1, 2: send_byte(8'($urandom_range(32, 126)));
                3: send_byte(8'($urandom_range(0, 255)));
                4: send_byte($urandom_range(0, 1) ? CH_TAB : CH_LF);
                5, 6: begin
                    send_esc(pick_letter());
                    k = 2;
                end
                7: begin
                    send_goto(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    k = 4;
                end
                8: begin
                    send_esc($urandom_range(0, 1) ? "b" : "c");
                    send_byte(8'($urandom_range(0, 255)));
                    k = 3;
                end
                default: send_byte(8'($urandom_range(0, 31)));
            endcase
        end
    endtask

    task automatic test_settings();
        write_reg(CFG_COLS, 8'd1);
        write_reg(CFG_ROWS, 8'd1);
        write_reg(CFG_VBELL, 8'd1);
        write_reg(CFG_NLCR, 8'd0);
        random_mix(10);
        write_reg(CFG_COLS, 8'd0);
        write_reg(CFG_ROWS, 8'd0);
        random_mix(10);
        write_reg(CFG_COLS, 8'd255);
        write_reg(CFG_ROWS, 8'd255);
        write_reg(CFG_VBELL, 8'd0);
        random_mix(15);
        write_reg(CFG_COLS, 8'd128);
        write_reg(CFG_ROWS, 8'd127);
        send_goto(8'd10, 8'd20);
        random_mix(10);
        write_reg(CFG_COLS, 8'd13);
        write_reg(CFG_ROWS, 8'd4);
        write_reg(CFG_NLCR, 8'd1);
        random_mix(20);
    endtask

    task automatic test_backpressure();
        drain();
        hold_req = 300;
        @(posedge i_clk);
        for (int i = 0; i < 20; i++) send_byte(CH_TAB);
        random_mix(10);
    endtask

    task automatic test_random();
        write_reg(CFG_COLS, 8'd80);
        write_reg(CFG_ROWS, 8'd25);
        random_mix(60);
    endtask

    initial begin
        scr_cols = 80;
        scr_rows = 25;
        vbell = 0;
        lf_cr = 1;
        esc_st = ESC_PLAIN;
        cur_col = 0;
        cur_row = 0;
        sav_col = 0;
        sav_row = 0;
        wrap_en = 1;
        cur_on = 1;
        rev_vid = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_text_and_controls();
        test_escapes();
        test_settings();
        test_backpressure();
        test_random();
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* vt52_escape_decoder.f */
rtl/vt52_pkg.sv
rtl/vt52_stream_if.sv
rtl/vt52_front.sv
rtl/vt52_queue.sv
rtl/vt52_back.sv
rtl/vt52_escape_decoder.sv
tb/sv/tb.sv
